FILE: sv/vhd_sector_translator_defines.svh
// assertion macros for the sector translator
`ifndef VHD_SECTOR_TRANSLATOR_DEFINES_SVH
`define VHD_SECTOR_TRANSLATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define VST_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define VST_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define VST_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define VST_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif

`endif

FILE: sv/vst_pkg.sv
// shared types and constants of the sector translator
`default_nettype none
package vst_pkg;

    localparam int DEF_TABLE_DEPTH       = 256;
    localparam int DEF_MAX_BLOCK_SECTORS = 1024;
    localparam int CFG_AW                = 3;

    localparam logic [CFG_AW-1:0] CFG_DISK_MODE     = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_BLOCK_LOG2    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_BITMAP_SECS   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_IMAGE_SECS    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_TABLE_ENTRIES = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_EXPAND        = 3'd5;

    localparam logic [1:0] FUNC_LOAD_TABLE  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_BITMAP = 2'd1;
    localparam logic [1:0] FUNC_READ        = 2'd2;
    localparam logic [1:0] FUNC_WRITE       = 2'd3;

    localparam logic [1:0] MODE_RAW      = 2'd0;
    localparam logic [1:0] MODE_FIXED    = 2'd1;
    localparam logic [1:0] MODE_DYNAMIC  = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    localparam logic [31:0] NO_BLOCK = 32'hffff_ffff;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] sector;
        logic [7:0]  entry_index;
        logic [31:0] entry_value;
        logic [12:0] word_index;
        logic [31:0] bitmap_word;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] phys_sector;
        logic        zero_fill;
        logic        bitmap_update;
        logic [31:0] bitmap_sector;
        logic        block_allocated;
        logic [31:0] new_block_start;
    } t_out;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_RANGE,
        RES_REFUSED,
        RES_LINEAR,
        RES_ZF,
        RES_ZF_BMP,
        RES_READ,
        RES_WRITE
    } t_res_kind;

    typedef struct packed {
        logic      capture;
        logic      tab_load;
        logic      bm_load;
        logic      load_start;
        logic      alloc;
        logic      clr;
        logic      bm_set;
        logic      res_we;
        t_res_kind res_kind;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       dyn;
        logic       lin_err;
        logic       dyn_err;
        logic       tab_none;
        logic       grow_bad;
        logic       bsec_out;
        logic       phys_out;
        logic       isset;
        logic       clr_last;
    } t_stat;

endpackage
`default_nettype wire

FILE: sv/vst_ram.sv
// generic single port ram with registered read
`default_nettype none
module vst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: sv/vst_ctrl.sv
// controller state machine of the sector translator
`default_nettype none
`include "vhd_sector_translator_defines.svh"
module vst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               o_done,
    output vst_pkg::t_cmd      o_cmd,
    input  wire vst_pkg::t_stat i_stat
);
    import vst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_TLOOK, S_CLEAR, S_BRD, S_BCHK
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.capture = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_done     = 1'b1;
                n_state    = S_IDLE;
                cmd.res_we = 1'b1;
                if (i_stat.func == FUNC_LOAD_TABLE) begin
                    cmd.tab_load = 1'b1;
                    cmd.res_kind = RES_ZERO;
                end else if (i_stat.func == FUNC_LOAD_BITMAP) begin
                    cmd.bm_load  = 1'b1;
                    cmd.res_kind = RES_ZERO;
                end else if (!i_stat.dyn) begin
                    cmd.res_kind = i_stat.lin_err ? RES_RANGE : RES_LINEAR;
                end else if (i_stat.dyn_err) begin
                    cmd.res_kind = RES_RANGE;
                end else begin
                    n_done     = 1'b0;
                    cmd.res_we = 1'b0;
                    n_state    = S_TLOOK;
                end
            end
            S_TLOOK: begin
                if (i_stat.tab_none) begin
                    if (i_stat.func == FUNC_READ) begin
                        cmd.res_we   = 1'b1;
                        cmd.res_kind = RES_ZF;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end else if (i_stat.grow_bad) begin
                        cmd.res_we   = 1'b1;
                        cmd.res_kind = RES_REFUSED;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        cmd.alloc = 1'b1;
                        n_state   = S_CLEAR;
                    end
                end else begin
                    cmd.load_start = 1'b1;
                    n_state        = S_BRD;
                end
            end
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                if (i_stat.bsec_out) begin
                    cmd.res_we   = 1'b1;
                    cmd.res_kind = RES_RANGE;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_BCHK;
                end
            end
            S_BCHK: begin
                cmd.res_we = 1'b1;
                n_done     = 1'b1;
                n_state    = S_IDLE;
                if (i_stat.func == FUNC_READ) begin
                    if (!i_stat.isset) begin
                        cmd.res_kind = RES_ZF_BMP;
                    end else if (i_stat.phys_out) begin
                        cmd.res_kind = RES_RANGE;
                    end else begin
                        cmd.res_kind = RES_READ;
                    end
                end else if (i_stat.phys_out) begin
                    cmd.res_kind = RES_RANGE;
                end else begin
                    cmd.res_kind = RES_WRITE;
                    cmd.bm_set   = !i_stat.isset;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_cmd  = cmd;

    `VST_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)
    `VST_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `VST_ASSERT_IMPL(a_set_on_write, i_clk, i_rst_n, cmd.bm_set,
        (i_stat.func == FUNC_WRITE) && !i_stat.isset)
endmodule
`default_nettype wire

FILE: sv/vst_dp.sv
// datapath of the sector translator: config, tables and result
`default_nettype none
module vst_dp #(
    parameter int TABLE_DEPTH       = vst_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_BLOCK_SECTORS = vst_pkg::DEF_MAX_BLOCK_SECTORS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [vst_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [31:0]               i_cfg_wdata,
    input  wire vst_pkg::t_in              i_item,
    input  wire vst_pkg::t_cmd             i_cmd,
    output vst_pkg::t_stat                 o_stat,
    output vst_pkg::t_out                  o_result
);
    import vst_pkg::*;

    localparam int WPB   = (MAX_BLOCK_SECTORS + 31) / 32;
    localparam int BMD   = TABLE_DEPTH * WPB;
    localparam int TW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BW    = (BMD > 1) ? $clog2(BMD) : 1;
    localparam int CW    = (WPB > 1) ? $clog2(WPB) : 1;

    logic [1:0]  r_mode;
    logic [3:0]  r_log2;
    logic [4:0]  r_bmsecs;
    logic [8:0]  r_entries;
    logic        r_expand;
    logic [31:0] r_image_end;
    t_in         r_item;
    logic [31:0] r_start;
    logic        r_fresh;
    logic [CW-1:0] r_cnt;
    t_out        r_res, n_res;

    logic [15:0] bs;
    logic [31:0] idx;
    logic [15:0] sib;
    logic [32:0] lin_phys;
    logic [33:0] newend, phys_dyn;
    logic [BW-1:0] base, bm_addr;
    logic [31:0] mask;
    logic [TW-1:0] tab_addr;
    logic [31:0] tab_wdata, tab_rdata, bm_wdata, bm_rdata;
    logic        tab_we, bm_we, tab_ok, bm_ok;

    assign bs       = 16'd1 << r_log2;
    assign idx      = r_item.sector >> r_log2;
    assign sib      = r_item.sector[15:0] & (bs - 16'd1);
    assign lin_phys = {1'b0, r_item.sector} + ((r_mode == MODE_FIXED) ? 33'd1 : 33'd0);
    assign newend   = {2'b0, r_image_end} + {18'd0, bs} + {29'd0, r_bmsecs};
    assign phys_dyn = {2'b0, r_start} + {29'd0, r_bmsecs} + {18'd0, sib};
    assign base     = BW'(idx[TW-1:0] * WPB);
    assign mask     = 32'h8000_0000 >> sib[4:0];
    assign tab_ok   = {24'd0, r_item.entry_index} < 32'(TABLE_DEPTH);
    assign bm_ok    = {19'd0, r_item.word_index} < 32'(BMD);

    always_comb begin
        tab_addr  = idx[TW-1:0];
        tab_wdata = r_image_end;
        tab_we    = i_cmd.alloc;
        if (i_cmd.tab_load) begin
            tab_addr  = TW'({24'd0, r_item.entry_index});
            tab_wdata = r_item.entry_value;
            tab_we    = tab_ok;
        end
    end

    always_comb begin
        bm_addr  = base + BW'(sib[15:5]);
        bm_wdata = bm_rdata | mask;
        bm_we    = i_cmd.bm_set;
        if (i_cmd.bm_load) begin
            bm_addr  = BW'({19'd0, r_item.word_index});
            bm_wdata = r_item.bitmap_word;
            bm_we    = bm_ok;
        end else if (i_cmd.clr) begin
            bm_addr  = base + BW'(r_cnt);
            bm_wdata = '0;
            bm_we    = 1'b1;
        end
    end

    vst_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH), .AW(TW)) u_table (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_addr  (tab_addr),
        .i_wdata (tab_wdata),
        .o_rdata (tab_rdata)
    );

    vst_ram #(.WIDTH(32), .DEPTH(BMD), .AW(BW)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_addr  (bm_addr),
        .i_wdata (bm_wdata),
        .o_rdata (bm_rdata)
    );

    always_comb begin
        o_stat.func     = r_item.func;
        o_stat.dyn      = (r_mode == MODE_DYNAMIC);
        o_stat.lin_err  = lin_phys > {1'b0, r_image_end};
        o_stat.dyn_err  = ({16'd0, bs} > 32'(MAX_BLOCK_SECTORS))
                          || (idx >= {23'd0, r_entries})
                          || (idx >= 32'(TABLE_DEPTH));
        o_stat.tab_none = (tab_rdata == NO_BLOCK);
        o_stat.grow_bad = !r_expand || (newend[33:32] != 2'b00);
        o_stat.bsec_out = r_start > r_image_end;
        o_stat.phys_out = phys_dyn > {2'b0, r_image_end};
        o_stat.isset    = |(bm_rdata & mask);
        o_stat.clr_last = ({{(32-CW){1'b0}}, r_cnt} == 32'(WPB - 1));
    end

    always_comb begin
        n_res = '0;
        case (i_cmd.res_kind)
            RES_RANGE:   n_res.status = ST_RANGE;
            RES_REFUSED: n_res.status = ST_REFUSED;
            RES_LINEAR:  n_res.phys_sector = lin_phys[31:0];
            RES_ZF:      n_res.zero_fill = 1'b1;
            RES_ZF_BMP: begin
                n_res.zero_fill     = 1'b1;
                n_res.bitmap_sector = r_start;
            end
            RES_READ: begin
                n_res.phys_sector   = phys_dyn[31:0];
                n_res.bitmap_sector = r_start;
            end
            RES_WRITE: begin
                n_res.phys_sector     = phys_dyn[31:0];
                n_res.bitmap_sector   = r_start;
                n_res.bitmap_update   = !o_stat.isset;
                n_res.block_allocated = r_fresh;
                n_res.new_block_start = r_fresh ? r_start : 32'd0;
            end
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RAW;
            r_log2      <= 4'd10;
            r_bmsecs    <= 5'd1;
            r_entries   <= 9'd0;
            r_expand    <= 1'b1;
            r_image_end <= 32'hffff_ffff;
            r_fresh     <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_DISK_MODE:     r_mode      <= i_cfg_wdata[1:0];
                    CFG_BLOCK_LOG2:    r_log2      <= i_cfg_wdata[3:0];
                    CFG_BITMAP_SECS:   r_bmsecs    <= i_cfg_wdata[4:0];
                    CFG_IMAGE_SECS:    r_image_end <= i_cfg_wdata - 32'd1;
                    CFG_TABLE_ENTRIES: r_entries   <= i_cfg_wdata[8:0];
                    CFG_EXPAND:        r_expand    <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                r_fresh <= 1'b0;
            end
            if (i_cmd.alloc) begin
                r_fresh     <= 1'b1;
                r_image_end <= newend[31:0];
                r_cnt       <= '0;
            end
            if (i_cmd.clr) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.load_start) begin
            r_start <= tab_rdata;
        end else if (i_cmd.alloc) begin
            r_start <= r_image_end;
        end
        if (i_cmd.res_we) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;
endmodule
`default_nettype wire

FILE: sv/vhd_sector_translator.sv
// top level of the sector translator
// loads, raw and fixed accesses: the execute state registers the result and the result strobe
// dynamic accesses: go on through a table read, then a bitmap read and, for a write, a bitmap update
// a write that appends a block first clears each bitmap word of that block
// no new start until the result strobe; the receiver takes each result unconditionally
// synchronous active-low reset clears control and config; table and bitmap are not cleared
`default_nettype none
module vhd_sector_translator #(
    parameter int TABLE_DEPTH       = vst_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_BLOCK_SECTORS = vst_pkg::DEF_MAX_BLOCK_SECTORS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire vst_pkg::t_in              i_item,
    output logic                           o_done,
    output vst_pkg::t_out                  o_result,
    input  wire logic                      i_cfg_we,
    input  wire logic [vst_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [31:0]               i_cfg_wdata
);
    import vst_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    vst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    vst_dp #(
        .TABLE_DEPTH       (TABLE_DEPTH),
        .MAX_BLOCK_SECTORS (MAX_BLOCK_SECTORS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (o_result)
    );
endmodule
`default_nettype wire

FILE: test/vhd_sector_translator_tb.sv
// testbench for the sector translator: directed and random transactions with a predictor
`default_nettype none
module vhd_sector_translator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vst_pkg::*;

    localparam int WORDS_PER_BLOCK = (DEF_MAX_BLOCK_SECTORS + 31) / 32;
    localparam int STALL_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int IN_BITS         = $bits(t_in);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_in                   i_item = '0;
    logic                  o_done;
    t_out                  o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]     i_cfg_addr = '0;
    logic [31:0]           i_cfg_wdata = '0;

    vhd_sector_translator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // shadow copy of the translator state
    logic [1:0]  disk_mode = MODE_RAW;
    logic [3:0]  block_log2 = 4'd10;
    logic [4:0]  bitmap_secs = 5'd1;
    logic [8:0]  table_entries = 9'd0;
    logic        expand_en = 1'b1;
    logic [31:0] image_end = 32'hffff_ffff;
    logic [31:0] alloc_table [DEF_TABLE_DEPTH];
    logic [31:0] bitmap_mem [DEF_TABLE_DEPTH * WORDS_PER_BLOCK];
    bit          table_known [DEF_TABLE_DEPTH];
    bit          bitmap_known [DEF_TABLE_DEPTH * WORDS_PER_BLOCK];

    t_out        pending_results [$];
    int          errors = 0;
    bit          allow_idle = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out translate_sector(input t_in it);
        t_out        r;
        logic [63:0] phys, bsec, newend, bs;
        logic [31:0] idx, sib, blk_start, word;
        logic [4:0]  bitpos;
        bit          isset, fresh;
        r = '0;
        fresh = 1'b0;
        if (it.func == FUNC_LOAD_TABLE) begin
            alloc_table[it.entry_index] = it.entry_value;
            table_known[it.entry_index] = 1'b1;
            return r;
        end
        if (it.func == FUNC_LOAD_BITMAP) begin
            bitmap_mem[it.word_index] = it.bitmap_word;
            bitmap_known[it.word_index] = 1'b1;
            return r;
        end
        if (disk_mode != MODE_DYNAMIC) begin
            phys = {32'b0, it.sector} + ((disk_mode == MODE_FIXED) ? 64'd1 : 64'd0);
            if (phys > {32'b0, image_end}) r.status = ST_RANGE;
            else r.phys_sector = phys[31:0];
            return r;
        end
        bs = 64'd1 << block_log2;
        idx = it.sector >> block_log2;
        sib = it.sector & (bs[31:0] - 32'd1);
        if (bs > DEF_MAX_BLOCK_SECTORS || idx >= table_entries || idx >= DEF_TABLE_DEPTH) begin
            r.status = ST_RANGE;
            return r;
        end
        blk_start = alloc_table[idx];
        if (blk_start == NO_BLOCK) begin
            if (it.func == FUNC_READ) begin
                r.zero_fill = 1'b1;
                return r;
            end
            newend = {32'b0, image_end} + bs + bitmap_secs;
            if (!expand_en || newend > 64'hffff_ffff) begin
                r.status = ST_REFUSED;
                return r;
            end
            blk_start = image_end;
            alloc_table[idx] = blk_start;
            image_end = newend[31:0];
            for (int k = 0; k < WORDS_PER_BLOCK; k++) begin
                bitmap_mem[idx * WORDS_PER_BLOCK + k] = '0;
                bitmap_known[idx * WORDS_PER_BLOCK + k] = 1'b1;
            end
            fresh = 1'b1;
        end
        bsec = {32'b0, blk_start} + (sib >> 12);
        if (bsec > {32'b0, image_end}) begin
            r.status = ST_RANGE;
            return r;
        end
        word = idx * WORDS_PER_BLOCK + (sib >> 5);
        bitpos = 5'd31 - sib[4:0];
        isset = bitmap_mem[word][bitpos];
        phys = {32'b0, blk_start} + bitmap_secs + sib;
        if (it.func == FUNC_READ) begin
            if (!isset) begin
                r.zero_fill = 1'b1;
                r.bitmap_sector = bsec[31:0];
            end else if (phys > {32'b0, image_end}) begin
                r.status = ST_RANGE;
            end else begin
                r.phys_sector = phys[31:0];
                r.bitmap_sector = bsec[31:0];
            end
            return r;
        end
        if (phys > {32'b0, image_end}) begin
            r.status = ST_RANGE;
            return r;
        end
        r.phys_sector = phys[31:0];
        r.bitmap_sector = bsec[31:0];
        if (!isset) begin
            bitmap_mem[word][bitpos] = 1'b1;
            r.bitmap_update = 1'b1;
        end
        if (fresh) begin
            r.block_allocated = 1'b1;
            r.new_block_start = blk_start;
        end
        return r;
    endfunction

    function automatic t_in random_item(input logic [1:0] func);
        t_in it;
        it = IN_BITS'({$urandom, $urandom, $urandom, $urandom});
        it.func = func;
        return it;
    endfunction

    task automatic send_item(input t_in it);
        int gap;
        gap = (allow_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        repeat (gap + 1) @(posedge i_clk);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pending_results.insert(pending_results.size(), translate_sector(it));
        start <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        case (addr)
            CFG_DISK_MODE:     disk_mode = data[1:0];
            CFG_BLOCK_LOG2:    block_log2 = data[3:0];
            CFG_BITMAP_SECS:   bitmap_secs = data[4:0];
            CFG_IMAGE_SECS:    image_end = data - 32'd1;
            CFG_TABLE_ENTRIES: table_entries = data[8:0];
            CFG_EXPAND:        expand_en = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [1:0] mode, input logic [3:0] log2,
                             input logic [4:0] bsecs, input logic [31:0] img,
                             input logic [8:0] entries, input logic expand);
        wait_idle();
        write_reg(CFG_DISK_MODE, {30'b0, mode});
        write_reg(CFG_BLOCK_LOG2, {28'b0, log2});
        write_reg(CFG_BITMAP_SECS, {27'b0, bsecs});
        write_reg(CFG_IMAGE_SECS, img);
        write_reg(CFG_TABLE_ENTRIES, {23'b0, entries});
        write_reg(CFG_EXPAND, {31'b0, expand});
    endtask

    task automatic access(input logic [1:0] func, input logic [31:0] sector);
        t_in it;
        it = random_item(func);
        it.sector = sector;
        send_item(it);
    endtask

    task automatic load_entry(input logic [7:0] idx, input logic [31:0] value);
        t_in it;
        it = random_item(FUNC_LOAD_TABLE);
        it.entry_index = idx;
        it.entry_value = value;
        send_item(it);
    endtask

    task automatic load_word(input logic [12:0] widx, input logic [31:0] value);
        t_in it;
        it = random_item(FUNC_LOAD_BITMAP);
        it.word_index = widx;
        it.bitmap_word = value;
        send_item(it);
    endtask

    function automatic logic [31:0] pick_block_start();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12) return NO_BLOCK;
        if (roll < 17) return $urandom;
        return $urandom_range(0, image_end);
    endfunction

    // loads the table entry and bitmap word that a dynamic access will look at
    task automatic prime_stores(input logic [31:0] sector);
        logic [31:0] idx, sib;
        if (disk_mode != MODE_DYNAMIC || block_log2 > 4'd10) return;
        idx = sector >> block_log2;
        sib = sector & ((32'd1 << block_log2) - 32'd1);
        if (idx >= table_entries) return;
        if (!table_known[idx]) load_entry(idx[7:0], pick_block_start());
        if (alloc_table[idx] != NO_BLOCK && !bitmap_known[idx * WORDS_PER_BLOCK + (sib >> 5)])
            load_word(13'(idx * WORDS_PER_BLOCK + (sib >> 5)), $urandom);
    endtask

    task automatic test_linear_modes();
        configure(MODE_RAW, 4'd10, 5'd1, 32'd0, 9'd0, 1'b1);
        access(FUNC_READ, 32'd0);
        access(FUNC_WRITE, 32'hffff_ffff);
        configure(MODE_RAW, 4'd10, 5'd1, 32'd100, 9'd0, 1'b1);
        access(FUNC_READ, 32'd99);
        access(FUNC_WRITE, 32'd100);
        configure(MODE_RESERVED, 4'd10, 5'd1, 32'd100, 9'd0, 1'b1);
        access(FUNC_READ, 32'd50);
        configure(MODE_FIXED, 4'd10, 5'd1, 32'd100, 9'd0, 1'b1);
        access(FUNC_READ, 32'd98);
        access(FUNC_WRITE, 32'd99);
        configure(MODE_FIXED, 4'd10, 5'd1, 32'd0, 9'd0, 1'b1);
        access(FUNC_READ, 32'hffff_ffff);
    endtask

    task automatic test_dynamic_directed();
        configure(MODE_DYNAMIC, 4'd3, 5'd1, 32'd1000, 9'd4, 1'b1);
        load_entry(8'd0, 32'd10);
        load_entry(8'd1, NO_BLOCK);
        load_entry(8'd2, 32'd990);
        load_entry(8'd3, NO_BLOCK);
        load_word(13'd0, 32'h8000_0000);
        load_word(13'(2 * WORDS_PER_BLOCK), 32'h0000_0000);
        load_entry(8'd255, 32'hffff_ffff);
        load_word(13'd8191, 32'hffff_ffff);
        access(FUNC_READ, 32'd0);
        access(FUNC_READ, 32'd1);
        access(FUNC_WRITE, 32'd1);
        access(FUNC_READ, 32'd8);
        access(FUNC_WRITE, 32'd9);
        access(FUNC_READ, 32'd9);
        access(FUNC_WRITE, 32'd23);
        access(FUNC_READ, 32'd32);
        configure(MODE_DYNAMIC, 4'd11, 5'd16, 32'd1000, 9'd4, 1'b1);
        access(FUNC_READ, 32'd0);
        configure(MODE_DYNAMIC, 4'd3, 5'd1, 32'd2000, 9'd4, 1'b0);
        access(FUNC_WRITE, 32'd24);
        configure(MODE_DYNAMIC, 4'd3, 5'd1, 32'hffff_ffff, 9'd4, 1'b1);
        access(FUNC_WRITE, 32'd24);
        configure(MODE_DYNAMIC, 4'd3, 5'd1, 32'd1000, 9'd4, 1'b1);
        load_entry(8'd0, 32'd5000);
        access(FUNC_READ, 32'd0);
    endtask

    task automatic run_random_phase(input int count);
        t_in         it;
        logic [31:0] idx, sib, sector;
        int          roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (disk_mode == MODE_DYNAMIC && roll < 75) begin
                idx = (table_entries == 0) ? 32'd0 :
                      ($urandom_range(0, 19) == 0 ? table_entries : $urandom_range(0, table_entries - 1));
                sib = $urandom & ((32'd1 << block_log2) - 32'd1);
                sector = (idx << block_log2) | sib;
                prime_stores(sector);
                access($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ, sector);
            end else begin
                it = random_item(2'($urandom_range(0, 3)));
                if (it.func == FUNC_READ || it.func == FUNC_WRITE) begin
                    if (disk_mode != MODE_DYNAMIC && $urandom_range(0, 1))
                        it.sector = image_end - 32'($urandom_range(0, 2));
                    prime_stores(it.sector);
                end
                send_item(it);
            end
        end
    endtask

    task automatic test_random();
        logic [3:0] log2;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: configure(MODE_RAW, 4'd10, 5'd1, $urandom, 9'd0, 1'b1);
                1: configure(MODE_FIXED, 4'd0, 5'd1, $urandom_range(0, 1000), 9'd0, 1'b0);
                2: configure(MODE_DYNAMIC, 4'd0, 5'd16, 32'd200000, 9'd256, 1'b1);
                3: configure(MODE_DYNAMIC, 4'd10, 5'd1, 32'd300000, 9'd256, 1'b1);
                4: configure(MODE_DYNAMIC, 4'd5, 5'd8, 32'hffff_f000, 9'd16, 1'b1);
                default: begin
                    log2 = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                                      : 4'($urandom_range(0, 10));
                    configure(($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : MODE_DYNAMIC,
                              log2, 5'($urandom_range(1, 16)), $urandom_range(1000, 400000),
                              9'($urandom_range(0, 256)), 1'($urandom_range(0, 1)));
                end
            endcase
            if (ph == 9) allow_idle = 1'b0;
            run_random_phase(ph < 2 ? 100 : 150);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] expv, input logic [31:0] act);
        if (expv !== act) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, expv, act);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual %h", $time, o_result);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_result.status));
                check_field("phys_sector", want.phys_sector, o_result.phys_sector);
                check_field("zero_fill", 32'(want.zero_fill), 32'(o_result.zero_fill));
                check_field("bitmap_update", 32'(want.bitmap_update), 32'(o_result.bitmap_update));
                check_field("bitmap_sector", want.bitmap_sector, o_result.bitmap_sector);
                check_field("block_allocated", 32'(want.block_allocated),
                            32'(o_result.block_allocated));
                check_field("new_block_start", want.new_block_start, o_result.new_block_start);
            end
        end
    end

    int stall_count = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) stall_count <= 0;
        else stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_linear_modes();
        test_dynamic_directed();
        test_random();
        wait_idle();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
